### hw/rtl/tsni_pkg.sv
// shared types and constants for the tls server-name extractor
// used by the controller, the datapath and the top level
package tsni_pkg;

  localparam int MAX_BYTES_DEF = 2048;
  localparam int MAX_NAME_DEF  = 256;

  localparam int POS_W       = 17;
  localparam int LEN_W       = 9;
  localparam int CHUNK_BYTES = 4;

  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  VER_MAJOR       = 8'h03;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0]  NAME_TYPE_HOST  = 8'h00;
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;

  localparam int HDR_LEN     = 5;
  localparam int RANDOM_LEN  = 32;
  localparam int HELLO_FIXED = HDR_LEN + 4 + 2 + RANDOM_LEN;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE         = 4'd0,
    OP_LD_HI        = 4'd1,
    OP_LD_REC       = 4'd2,
    OP_POS_INIT     = 4'd3,
    OP_POS_ADD_B1   = 4'd4,
    OP_POS_ADD_W2   = 4'd5,
    OP_LD_END       = 4'd6,
    OP_LD_ETYPE     = 4'd7,
    OP_LD_ELEN      = 4'd8,
    OP_POS_ADD_ELEN = 4'd9,
    OP_LD_NL        = 4'd10,
    OP_NAME_INIT    = 4'd11
  } dp_op_t;

  typedef struct packed {
    logic       wr;
    logic       cnt_clr;
    logic       rd_en;
    logic       rd_pos;
    logic [2:0] rd_off;
    dp_op_t     op;
    logic       fetch;
    logic       out_chunk;
    logic       out_none;
    logic       out_long;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_lt5;
    logic cnt_le5;
    logic rec_short;
    logic b_hdr;
    logic b_ver;
    logic b_hello;
    logic b_host;
    logic p1_gt_n;
    logic p2_gt_n;
    logic walk_done;
    logic ext_zero;
    logic ext_fit;
    logic name_fit;
    logic nl_zero;
    logic nl_big;
    logic chunk_ready;
    logic name_last;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/tsni_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tsni_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tsni_ctrl.sv
// controller sequencing byte capture, record parse and chunk output
// depends on tsni_pkg
module tsni_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               last_byte,
  output logic               byte_stall,
  input  tsni_pkg::dp_stat_t stat,
  output tsni_pkg::dp_cmd_t  cmd
);

  import tsni_pkg::*;

  typedef enum logic [30:0] {
    S_RECV     = 31'h0000_0001,
    S_HDR0     = 31'h0000_0002,
    S_HDR1     = 31'h0000_0004,
    S_HDR2     = 31'h0000_0008,
    S_HDR3     = 31'h0000_0010,
    S_HDR4     = 31'h0000_0020,
    S_HDR5     = 31'h0000_0040,
    S_HDR6     = 31'h0000_0080,
    S_SID      = 31'h0000_0100,
    S_SID_CHK  = 31'h0000_0200,
    S_CS_HI    = 31'h0000_0400,
    S_CS_LO    = 31'h0000_0800,
    S_CS_CHK   = 31'h0000_1000,
    S_CM       = 31'h0000_2000,
    S_CM_CHK   = 31'h0000_4000,
    S_EL_HI    = 31'h0000_8000,
    S_EL_LO    = 31'h0001_0000,
    S_EXT      = 31'h0002_0000,
    S_ET_HI    = 31'h0004_0000,
    S_ET_LO    = 31'h0008_0000,
    S_EN_HI    = 31'h0010_0000,
    S_EN_LO    = 31'h0020_0000,
    S_SNI      = 31'h0040_0000,
    S_SNI_TYPE = 31'h0080_0000,
    S_NL_HI    = 31'h0100_0000,
    S_NL_LO    = 31'h0200_0000,
    S_NL_CHK   = 31'h0400_0000,
    S_FETCH    = 31'h0800_0000,
    S_OUT      = 31'h1000_0000,
    S_NONE     = 31'h2000_0000,
    S_LONG     = 31'h4000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign byte_stall = (state != S_RECV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_NONE;
    case (state)
      S_RECV: begin
        cmd.wr = byte_valid;
        if (byte_valid && last_byte) begin
          state_next = S_HDR0;
        end
      end
      S_HDR0: begin
        if (stat.cnt_lt5) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = 3'd0;
          state_next = S_HDR1;
        end
      end
      S_HDR1: begin
        if (!stat.b_hdr) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = 3'd1;
          state_next = S_HDR2;
        end
      end
      S_HDR2: begin
        if (!stat.b_ver) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = 3'd3;
          state_next = S_HDR3;
        end
      end
      S_HDR3: begin
        cmd.op     = OP_LD_HI;
        cmd.rd_en  = 1'b1;
        cmd.rd_off = 3'd4;
        state_next = S_HDR4;
      end
      S_HDR4: begin
        cmd.op     = OP_LD_REC;
        state_next = S_HDR5;
      end
      S_HDR5: begin
        if (stat.rec_short || stat.cnt_le5) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_off = 3'(HDR_LEN);
          cmd.op     = OP_POS_INIT;
          state_next = S_HDR6;
        end
      end
      S_HDR6: begin
        if (!stat.b_hello || stat.p1_gt_n) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          state_next = S_SID;
        end
      end
      S_SID: begin
        cmd.op     = OP_POS_ADD_B1;
        state_next = S_SID_CHK;
      end
      S_SID_CHK: begin
        if (stat.p2_gt_n) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          state_next = S_CS_HI;
        end
      end
      S_CS_HI: begin
        cmd.op     = OP_LD_HI;
        cmd.rd_en  = 1'b1;
        cmd.rd_pos = 1'b1;
        cmd.rd_off = 3'd1;
        state_next = S_CS_LO;
      end
      S_CS_LO: begin
        cmd.op     = OP_POS_ADD_W2;
        state_next = S_CS_CHK;
      end
      S_CS_CHK: begin
        if (stat.p1_gt_n) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          state_next = S_CM;
        end
      end
      S_CM: begin
        cmd.op     = OP_POS_ADD_B1;
        state_next = S_CM_CHK;
      end
      S_CM_CHK: begin
        if (stat.p2_gt_n) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          state_next = S_EL_HI;
        end
      end
      S_EL_HI: begin
        cmd.op     = OP_LD_HI;
        cmd.rd_en  = 1'b1;
        cmd.rd_pos = 1'b1;
        cmd.rd_off = 3'd1;
        state_next = S_EL_LO;
      end
      S_EL_LO: begin
        cmd.op     = OP_LD_END;
        state_next = S_EXT;
      end
      S_EXT: begin
        if (stat.walk_done) begin
          state_next = S_NONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          state_next = S_ET_HI;
        end
      end
      S_ET_HI: begin
        cmd.op     = OP_LD_HI;
        cmd.rd_en  = 1'b1;
        cmd.rd_pos = 1'b1;
        cmd.rd_off = 3'd1;
        state_next = S_ET_LO;
      end
      S_ET_LO: begin
        cmd.op     = OP_LD_ETYPE;
        cmd.rd_en  = 1'b1;
        cmd.rd_pos = 1'b1;
        cmd.rd_off = 3'd2;
        state_next = S_EN_HI;
      end
      S_EN_HI: begin
        cmd.op     = OP_LD_HI;
        cmd.rd_en  = 1'b1;
        cmd.rd_pos = 1'b1;
        cmd.rd_off = 3'd3;
        state_next = S_EN_LO;
      end
      S_EN_LO: begin
        cmd.op     = OP_LD_ELEN;
        state_next = S_SNI;
      end
      S_SNI: begin
        if (stat.ext_zero && stat.ext_fit) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          cmd.rd_off = 3'd2;
          state_next = S_SNI_TYPE;
        end else begin
          cmd.op     = OP_POS_ADD_ELEN;
          state_next = S_EXT;
        end
      end
      S_SNI_TYPE: begin
        if (!stat.b_host) begin
          cmd.op     = OP_POS_ADD_ELEN;
          state_next = S_EXT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pos = 1'b1;
          cmd.rd_off = 3'd3;
          state_next = S_NL_HI;
        end
      end
      S_NL_HI: begin
        cmd.op     = OP_LD_HI;
        cmd.rd_en  = 1'b1;
        cmd.rd_pos = 1'b1;
        cmd.rd_off = 3'd4;
        state_next = S_NL_LO;
      end
      S_NL_LO: begin
        cmd.op     = OP_LD_NL;
        state_next = S_NL_CHK;
      end
      S_NL_CHK: begin
        if (!stat.name_fit) begin
          cmd.op     = OP_POS_ADD_ELEN;
          state_next = S_EXT;
        end else if (stat.nl_zero) begin
          state_next = S_NONE;
        end else if (stat.nl_big) begin
          state_next = S_LONG;
        end else begin
          cmd.op     = OP_NAME_INIT;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.chunk_ready) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_chunk = 1'b1;
          if (stat.name_last) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_RECV;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_NONE: begin
        if (stat.out_free) begin
          cmd.out_none = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_RECV;
        end
      end
      S_LONG: begin
        if (stat.out_free) begin
          cmd.out_long = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_RECV;
        end
      end
      default: begin
        state_next = S_RECV;
      end
    endcase
  end

endmodule

### hw/rtl/tsni_dpath.sv
// datapath: byte buffer ram, parse cursor and bounds, name chunk assembly
// and the result word register; depends on tsni_pkg and tsni_ram
module tsni_dpath #(
  parameter int MAX_BYTES = tsni_pkg::MAX_BYTES_DEF,
  parameter int MAX_NAME  = tsni_pkg::MAX_NAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tsni_pkg::dp_cmd_t               cmd,
  output tsni_pkg::dp_stat_t              stat,
  input  logic [7:0]                      data_byte,
  output logic                            chunk_valid,
  input  logic                            chunk_stall,
  output logic [1:0]                      status,
  output logic [tsni_pkg::LEN_W-1:0]      name_length,
  output logic [31:0]                     chunk_data,
  output logic [2:0]                      chunk_bytes,
  output logic                            last_chunk
);

  import tsni_pkg::*;

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int AW    = $clog2(MAX_BYTES);
  localparam int XW    = POS_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BYTES);
  localparam logic [15:0]      NAME_MAX = 16'(MAX_NAME);

  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] pos;
  logic [15:0]      rec;
  logic [7:0]       hi;
  logic [CNT_W-1:0] ext_end;
  logic [15:0]      elen;
  logic             etype_zero;
  logic [15:0]      nl;
  logic [CNT_W-1:0] start;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] idx;
  logic [2:0]       slot;
  logic [31:0]      acc;
  logic             name_pend;

  logic [7:0]       rdata;
  logic [15:0]      word16;
  logic             cnt_full;
  logic             fetch_more;
  logic             fetch_go;
  logic             out_load;
  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    n_x;
  logic [XW-1:0]    end_x;
  logic [XW-1:0]    end_sum;
  logic [CNT_W-1:0] end_next;
  logic [POS_W-1:0] pos_p5;
  logic [POS_W-1:0] rd_base;
  logic [POS_W-1:0] rd_sum;
  logic [POS_W-1:0] name_sum;
  logic [AW-1:0]    raddr;
  logic [31:0]      chunk_word;

  assign word16     = {hi, rdata};
  assign cnt_full   = (cnt == CNT_MAX);
  assign fetch_more = (slot != 3'(CHUNK_BYTES)) && (idx != len);
  assign fetch_go   = cmd.fetch && fetch_more;
  assign out_load   = cmd.out_chunk || cmd.out_none || cmd.out_long;

  assign pos_x    = XW'(pos);
  assign n_x      = XW'(cnt);
  assign end_x    = XW'(ext_end);
  assign end_sum  = pos_x + XW'(2) + XW'(word16);
  assign end_next = (end_sum > n_x) ? cnt : end_sum[CNT_W-1:0];
  assign pos_p5   = pos + POS_W'(5);

  assign rd_base  = cmd.rd_pos ? pos : '0;
  assign rd_sum   = rd_base + POS_W'(cmd.rd_off);
  assign name_sum = POS_W'(start) + POS_W'(idx);
  assign raddr    = fetch_go ? name_sum[AW-1:0] : rd_sum[AW-1:0];

  tsni_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.wr && !cnt_full),
    .waddr (cnt[AW-1:0]),
    .wdata (data_byte),
    .re    (cmd.rd_en || fetch_go),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (slot)
      3'd1:    chunk_word = {acc[7:0], 24'h0};
      3'd2:    chunk_word = {acc[15:0], 16'h0};
      3'd3:    chunk_word = {acc[23:0], 8'h0};
      default: chunk_word = acc;
    endcase
  end

  always_comb begin
    stat             = '0;
    stat.cnt_lt5     = cnt < CNT_W'(HDR_LEN);
    stat.cnt_le5     = cnt <= CNT_W'(HDR_LEN);
    stat.rec_short   = n_x < (XW'(rec) + XW'(HDR_LEN));
    stat.b_hdr       = (rdata == REC_HANDSHAKE);
    stat.b_ver       = (rdata == VER_MAJOR);
    stat.b_hello     = (rdata == HS_CLIENT_HELLO);
    stat.b_host      = (rdata == NAME_TYPE_HOST);
    stat.p1_gt_n     = (pos_x + XW'(1)) > n_x;
    stat.p2_gt_n     = (pos_x + XW'(2)) > n_x;
    stat.walk_done   = (pos_x + XW'(4)) > end_x;
    stat.ext_zero    = etype_zero;
    stat.ext_fit     = (pos_x + XW'(5)) <= end_x;
    stat.name_fit    = (pos_x + XW'(5) + XW'(nl)) <= end_x;
    stat.nl_zero     = (nl == 16'h0);
    stat.nl_big      = (nl > NAME_MAX);
    stat.chunk_ready = !fetch_more && !name_pend;
    stat.name_last   = (idx == len);
    stat.out_free    = !chunk_valid || !chunk_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      name_pend   <= 1'b0;
      chunk_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.wr && !cnt_full) begin
        cnt <= cnt + CNT_W'(1);
      end
      name_pend <= fetch_go;
      if (out_load) begin
        chunk_valid <= 1'b1;
      end else if (!chunk_stall) begin
        chunk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LD_HI:        hi <= rdata;
      OP_LD_REC:       rec <= word16;
      OP_POS_INIT:     pos <= POS_W'(HELLO_FIXED);
      OP_POS_ADD_B1:   pos <= pos + POS_W'(1) + POS_W'(rdata);
      OP_POS_ADD_W2:   pos <= pos + POS_W'(2) + POS_W'(word16);
      OP_LD_END: begin
        pos     <= pos + POS_W'(2);
        ext_end <= end_next;
      end
      OP_LD_ETYPE:     etype_zero <= (word16 == EXT_SERVER_NAME);
      OP_LD_ELEN: begin
        elen <= word16;
        pos  <= pos + POS_W'(4);
      end
      OP_POS_ADD_ELEN: pos <= pos + POS_W'(elen);
      OP_LD_NL:        nl <= word16;
      OP_NAME_INIT: begin
        start <= pos_p5[CNT_W-1:0];
        len   <= nl[LEN_W-1:0];
        idx   <= '0;
        slot  <= '0;
        acc   <= '0;
      end
      default: begin
      end
    endcase

    if (fetch_go) begin
      idx  <= idx + LEN_W'(1);
      slot <= slot + 3'd1;
    end
    if (name_pend) begin
      acc <= {acc[23:0], rdata};
    end

    if (cmd.out_chunk) begin
      slot        <= '0;
      acc         <= '0;
      status      <= ST_FOUND;
      name_length <= len;
      chunk_data  <= chunk_word;
      chunk_bytes <= slot;
      last_chunk  <= stat.name_last;
    end else if (cmd.out_none || cmd.out_long) begin
      status      <= cmd.out_long ? ST_LONG : ST_NONE;
      name_length <= '0;
      chunk_data  <= '0;
      chunk_bytes <= '0;
      last_chunk  <= 1'b1;
    end
  end

endmodule

### hw/rtl/tls_client_hello_sni_extractor_unit.sv
// Server-name extractor for the start of a TLS stream. Bytes are taken one
// per cycle into a MAX_BYTES-deep byte buffer; bytes past MAX_BYTES are
// dropped but their end flag still closes the buffer. After the final byte
// the input stalls while the controller walks the buffered record through
// the single read port of the buffer ram: first the header and hello
// prefix, then each extension in turn, reading further into a
// server_name candidate. A found name is then sent in 4-byte words, each
// built from up to four ram reads plus assembly, first byte in bits 31..24;
// otherwise one word reports no name or a name longer than MAX_NAME.
// Depends on tsni_pkg, tsni_ctrl, tsni_dpath and tsni_ram.
module tls_client_hello_sni_extractor_unit #(
  parameter int MAX_BYTES = tsni_pkg::MAX_BYTES_DEF,
  parameter int MAX_NAME  = tsni_pkg::MAX_NAME_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  output logic                       byte_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  output logic                       chunk_valid,
  input  logic                       chunk_stall,
  output logic [1:0]                 status,
  output logic [tsni_pkg::LEN_W-1:0] name_length,
  output logic [31:0]                chunk_data,
  output logic [2:0]                 chunk_bytes,
  output logic                       last_chunk
);

  import tsni_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsni_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .last_byte  (last_byte),
    .byte_stall (byte_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  tsni_dpath #(
    .MAX_BYTES (MAX_BYTES),
    .MAX_NAME  (MAX_NAME)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (data_byte),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .status      (status),
    .name_length (name_length),
    .chunk_data  (chunk_data),
    .chunk_bytes (chunk_bytes),
    .last_chunk  (last_chunk)
  );

endmodule

### test/testbench.sv
// self-checking testbench for tls_client_hello_sni_extractor_unit: builds client hello
// streams byte by byte, predicts every name word and checks them under random idling
// depends on tsni_pkg and the extractor rtl
module testbench;
  import tsni_pkg::*;

  localparam int BUF_BYTES   = MAX_BYTES_DEF;
  localparam int NAME_MAX    = MAX_NAME_DEF;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t          st;
    logic [LEN_W-1:0] len;
    logic [31:0]      data;
    logic [2:0]       nbytes;
    logic             fin;
  } sni_word_t;

  typedef struct {
    logic [7:0] rec_type, ver_major, hs_type, name_type;
    int sid_len, suite_len, comp_len, pre_exts, post_exts, big_ext;
    int name_len, second_len, nl_delta, rec_delta, blk_delta, trim, pad;
  } hello_knobs_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  logic [7:0]        data_byte = 8'h00;
  logic              last_byte = 1'b0;
  logic              chunk_valid;
  logic              chunk_stall = 1'b0;
  logic [1:0]        status;
  logic [LEN_W-1:0]  name_length;
  logic [31:0]       chunk_data;
  logic [2:0]        chunk_bytes;
  logic              last_chunk;

  logic [7:0]        held_buf [BUF_BYTES];
  int unsigned       held_count = 0;
  sni_word_t         expected_words [$];
  logic [7:0]        msg_q [$];
  int unsigned       mismatches = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  tls_client_hello_sni_extractor_unit uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .status      (status),
    .name_length (name_length),
    .chunk_data  (chunk_data),
    .chunk_bytes (chunk_bytes),
    .last_chunk  (last_chunk)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    chunk_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // predictor: buffered stream bytes and the name search over them
  function automatic int unsigned held_byte(input int unsigned i);
    if (i < held_count && i < BUF_BYTES) return 32'(held_buf[i]);
    return 0;
  endfunction

  function automatic int unsigned held_word(input int unsigned i);
    return (held_byte(i) << 8) | held_byte(i + 1);
  endfunction

  function automatic status_t find_host_name(output int unsigned npos,
                                             output int unsigned nlen);
    int unsigned n, pos, blk_end, ext_type, ext_len, nl;
    n = held_count;
    npos = 0;
    nlen = 0;
    if (n < HDR_LEN) return ST_NONE;
    if (held_byte(0) != REC_HANDSHAKE || held_byte(1) != VER_MAJOR) return ST_NONE;
    if (n < HDR_LEN + held_word(3)) return ST_NONE;
    if (n <= HDR_LEN) return ST_NONE;
    if (held_byte(HDR_LEN) != HS_CLIENT_HELLO) return ST_NONE;
    pos = HELLO_FIXED;
    if (pos >= n) return ST_NONE;
    pos += 1 + held_byte(pos);
    if (pos + 2 > n) return ST_NONE;
    pos += 2 + held_word(pos);
    if (pos + 1 > n) return ST_NONE;
    pos += 1 + held_byte(pos);
    if (pos + 2 > n) return ST_NONE;
    blk_end = pos + 2 + held_word(pos);
    pos += 2;
    if (blk_end > n) blk_end = n;
    while (pos + 4 <= blk_end) begin
      ext_type = held_word(pos);
      ext_len  = held_word(pos + 2);
      pos += 4;
      if (ext_type == EXT_SERVER_NAME && pos + 5 <= blk_end &&
          held_byte(pos + 2) == NAME_TYPE_HOST) begin
        nl = held_word(pos + 3);
        if (pos + 5 + nl <= blk_end) begin
          if (nl == 0) return ST_NONE;
          if (nl > NAME_MAX) return ST_LONG;
          npos = pos + 5;
          nlen = nl;
          return ST_FOUND;
        end
      end
      pos += ext_len;
    end
    return ST_NONE;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    status_t     st;
    int unsigned npos, nlen, k, j, cnt;
    sni_word_t   w;
    if (held_count < BUF_BYTES) begin
      held_buf[held_count] = b;
      held_count++;
    end
    if (!fin) return;
    st = find_host_name(npos, nlen);
    if (st != ST_FOUND) begin
      w.st = st;
      w.len = '0;
      w.data = '0;
      w.nbytes = '0;
      w.fin = 1'b1;
      expected_words.push_back(w);
    end else begin
      cnt = (nlen + 3) / 4;
      for (k = 0; k < cnt; k++) begin
        w.st = ST_FOUND;
        w.len = nlen[LEN_W-1:0];
        w.data = '0;
        w.nbytes = '0;
        for (j = 0; j < 4; j++) begin
          w.data = w.data << 8;
          if (k * 4 + j < nlen) begin
            w.data = w.data | held_byte(npos + k * 4 + j);
            w.nbytes++;
          end
        end
        w.fin = (k + 1 == cnt);
        expected_words.push_back(w);
      end
    end
    held_count = 0;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch: %s", what);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    sni_word_t want;
    if (!rst && byte_valid && !byte_stall) absorb_byte(data_byte, last_byte);
    if (!rst && chunk_valid && !chunk_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word arrived with nothing expected");
      end else begin
        want = expected_words.pop_front();
        if (status !== want.st || name_length !== want.len || chunk_data !== want.data ||
            chunk_bytes !== want.nbytes || last_chunk !== want.fin) begin
          report_mismatch($sformatf(
            "got st %0d len %0d data %h bytes %0d last %b, want %0d %0d %h %0d %b",
            status, name_length, chunk_data, chunk_bytes, last_chunk,
            want.st, want.len, want.data, want.nbytes, want.fin));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // stream construction
  function automatic void push_byte(input int v);
    msg_q.push_back(v[7:0]);
  endfunction

  function automatic void push_word(input int v);
    push_byte(v >> 8);
    push_byte(v);
  endfunction

  function automatic void put_filler(input int len);
    push_word($urandom_range(1, 16'hFFFF));
    push_word(len);
    repeat (len) push_byte($urandom_range(255));
  endfunction

  function automatic void put_server_name(input int ntype, input int len, input int delta);
    push_word(EXT_SERVER_NAME);
    push_word(len + 5);
    push_word(len + 3);
    push_byte(ntype);
    push_word(len + delta);
    repeat (len) push_byte($urandom_range(255));
  endfunction

  function automatic hello_knobs_t typical_hello(input int name_len);
    hello_knobs_t k;
    k.rec_type = REC_HANDSHAKE;
    k.ver_major = VER_MAJOR;
    k.hs_type = HS_CLIENT_HELLO;
    k.name_type = NAME_TYPE_HOST;
    k.sid_len = $urandom_range(32);
    k.suite_len = 2 * $urandom_range(1, 4);
    k.comp_len = $urandom_range(1, 2);
    k.pre_exts = $urandom_range(2);
    k.post_exts = $urandom_range(2);
    k.big_ext = 0;
    k.name_len = name_len;
    k.second_len = 0;
    k.nl_delta = 0;
    k.rec_delta = 0;
    k.blk_delta = 0;
    k.trim = 0;
    k.pad = 0;
    return k;
  endfunction

  function automatic void build_hello(input hello_knobs_t k);
    logic [7:0] ext_bytes [$];
    int         hs_len;
    msg_q.delete();
    repeat (k.pre_exts) put_filler($urandom_range(6));
    if (k.big_ext > 0) put_filler(k.big_ext);
    put_server_name(k.name_type, k.name_len, k.nl_delta);
    if (k.second_len > 0) put_server_name(NAME_TYPE_HOST, k.second_len, 0);
    repeat (k.post_exts) put_filler($urandom_range(6));
    ext_bytes = msg_q;
    msg_q.delete();
    hs_len = 2 + RANDOM_LEN + 1 + k.sid_len + 2 + k.suite_len + 1 + k.comp_len + 2 +
             ext_bytes.size();
    push_byte(k.rec_type);
    push_byte(k.ver_major);
    push_byte($urandom_range(4));
    push_word(hs_len + 4 + k.rec_delta);
    push_byte(k.hs_type);
    push_byte(hs_len >> 16);
    push_word(hs_len);
    push_byte(VER_MAJOR);
    push_byte($urandom_range(4));
    repeat (RANDOM_LEN) push_byte($urandom_range(255));
    push_byte(k.sid_len);
    repeat (k.sid_len) push_byte($urandom_range(255));
    push_word(k.suite_len);
    repeat (k.suite_len) push_byte($urandom_range(255));
    push_byte(k.comp_len);
    repeat (k.comp_len) push_byte($urandom_range(255));
    push_word(ext_bytes.size() + k.blk_delta);
    foreach (ext_bytes[i]) msg_q.push_back(ext_bytes[i]);
    repeat (k.pad) push_byte($urandom_range(255));
    repeat (k.trim) if (msg_q.size() > 1) void'(msg_q.pop_back());
  endfunction

  // handshake side
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic wait_for_drain();
    byte_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // directed tests
  task automatic test_short_buffers();
    int           cuts [3] = '{1, 4, 5};
    hello_knobs_t k;
    int           i;
    for (i = 0; i < 3; i++) begin
      msg_q.delete();
      push_byte(REC_HANDSHAKE);
      push_byte(VER_MAJOR);
      push_byte($urandom_range(4));
      push_word(0);
      while (msg_q.size() > cuts[i]) void'(msg_q.pop_back());
      send_buffer();
    end
    k = typical_hello(6);
    k.rec_type = 8'h17;
    build_hello(k);
    send_buffer();
    k = typical_hello(6);
    k.ver_major = 8'h02;
    build_hello(k);
    send_buffer();
  endtask

  task automatic test_found_names();
    int           lens [3] = '{1, 4, 5};
    int           i;
    for (i = 0; i < 3; i++) begin
      build_hello(typical_hello(lens[i]));
      send_buffer();
    end
  endtask

  task automatic test_name_limits();
    hello_knobs_t k;
    build_hello(typical_hello(NAME_MAX));
    send_buffer();
    build_hello(typical_hello(NAME_MAX + 1));
    send_buffer();
    build_hello(typical_hello(0));
    send_buffer();
    k = typical_hello(9);
    k.nl_delta = 1;
    build_hello(k);
    send_buffer();
    k = typical_hello(9);
    k.nl_delta = 16'hFFFF - 9;
    build_hello(k);
    send_buffer();
    k = typical_hello(7);
    k.name_type = 8'h01;
    build_hello(k);
    send_buffer();
    k.second_len = 11;
    build_hello(k);
    send_buffer();
  endtask

  task automatic test_bad_framing();
    hello_knobs_t k;
    int           cuts [4] = '{43, 44, 48, 52};
    int           i;
    k = typical_hello(8);
    k.hs_type = 8'h02;
    build_hello(k);
    send_buffer();
    k = typical_hello(8);
    k.rec_delta = 1;
    build_hello(k);
    send_buffer();
    k = typical_hello(8);
    k.blk_delta = -1;
    build_hello(k);
    send_buffer();
    // extension block longer than the buffer, record length cleared
    k = typical_hello(8);
    k.blk_delta = 200;
    build_hello(k);
    msg_q[3] = 8'h00;
    msg_q[4] = 8'h00;
    send_buffer();
    for (i = 0; i < 4; i++) begin
      k = typical_hello(8);
      k.sid_len = 0;
      k.suite_len = 2;
      k.comp_len = 1;
      build_hello(k);
      msg_q[3] = 8'h00;
      msg_q[4] = 8'h00;
      while (msg_q.size() > cuts[i]) void'(msg_q.pop_back());
      send_buffer();
    end
  endtask

  task automatic test_buffer_overflow();
    hello_knobs_t k;
    int           sizes [2] = '{BUF_BYTES, BUF_BYTES + 52};
    int           i;
    for (i = 0; i < 2; i++) begin
      k = typical_hello(12);
      k.sid_len = 0;
      k.pre_exts = 0;
      k.post_exts = 0;
      k.big_ext = 1900;
      build_hello(k);
      while (msg_q.size() < sizes[i]) push_byte($urandom_range(255));
      send_buffer();
    end
    k = typical_hello(12);
    k.big_ext = 2040;
    build_hello(k);
    msg_q[3] = 8'h00;
    msg_q[4] = 8'h00;
    send_buffer();
  endtask

  task automatic test_random_hellos(input int buffers);
    hello_knobs_t k;
    int           i, sel, nsel;
    for (i = 0; i < buffers; i++) begin
      if (i == buffers / 2) wait_for_drain();
      sel = $urandom_range(99);
      if (sel < 15) begin
        msg_q.delete();
        if ($urandom_range(1)) begin
          push_byte(REC_HANDSHAKE);
          push_byte(VER_MAJOR);
        end
        repeat ($urandom_range(1, 24)) push_byte($urandom_range(255));
      end else begin
        nsel = $urandom_range(99);
        if (nsel < 4) k = typical_hello($urandom_range(NAME_MAX - 16, NAME_MAX + 4));
        else if (nsel < 8) k = typical_hello(0);
        else k = typical_hello($urandom_range(1, 40));
        if ($urandom_range(9) == 0) k.sid_len = $urandom_range(33, 255);
        if ($urandom_range(4) == 0) k.second_len = $urandom_range(1, 20);
        if ($urandom_range(3) == 0) k.pad = $urandom_range(1, 8);
        if (sel >= 65) begin
          case ($urandom_range(7))
            0: k.rec_type = 8'($urandom_range(255));
            1: k.ver_major = 8'($urandom_range(255));
            2: k.hs_type = 8'($urandom_range(255));
            3: k.name_type = 8'($urandom_range(1, 255));
            4: k.nl_delta = $urandom_range(6) - 3;
            5: k.rec_delta = $urandom_range(1, 16);
            6: k.blk_delta = $urandom_range(16) - 8;
            default: k.trim = $urandom_range(1, 60);
          endcase
        end
        build_hello(k);
      end
      send_buffer();
    end
  endtask

  initial begin
    send_idle_pct = 33;
    recv_stall_pct = 54;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_short_buffers();
    test_found_names();
    test_name_limits();
    test_bad_framing();
    test_buffer_overflow();
    test_random_hellos(10);
    wait_for_drain();
    send_idle_pct = 54;
    recv_stall_pct = 33;
    test_random_hellos(10);
    wait_for_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_hellos(10);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
